// ----- hdl/cau_pkg.sv -----
// Shared types, codes and widths of the complex arithmetic unit.
`default_nettype none
package cau_pkg;
	localparam int FIELD_W   = 32;
	localparam int ACT_W     = 3;
	localparam int STAT_W    = 2;
	localparam int PROD_W    = 64;
	localparam int MAG_W     = 65;
	localparam int DEN_W     = 64;
	localparam int QBITS     = 34;
	localparam int SREM_W    = 35;
	localparam int LATENCY   = QBITS + 4;
	localparam int DEF_DATA_WIDTH = 32;
	localparam int DEF_FRAC_BITS  = 16;

	localparam logic [ACT_W-1:0] ACT_ADD = 3'd0;
	localparam logic [ACT_W-1:0] ACT_SUB = 3'd1;
	localparam logic [ACT_W-1:0] ACT_MUL = 3'd2;
	localparam logic [ACT_W-1:0] ACT_DIV = 3'd3;
	localparam logic [ACT_W-1:0] ACT_MAG = 3'd4;
	localparam logic [ACT_W-1:0] ACT_NEG = 3'd5;

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_SAT  = 2'd1;
	localparam logic [STAT_W-1:0] ST_DIV0 = 2'd2;

	localparam logic [1:0] KIND_DIRECT = 2'd0;
	localparam logic [1:0] KIND_DIV    = 2'd1;
	localparam logic [1:0] KIND_SQRT   = 2'd2;

	typedef struct packed {
		logic [1:0]        kind;
		logic              dz;
		logic              re_neg;
		logic              im_neg;
		logic [MAG_W-1:0]  re_mag;
		logic [MAG_W-1:0]  im_mag;
		logic [DEN_W-1:0]  den;
		logic [DEN_W-1:0]  re_rem;
		logic [DEN_W-1:0]  im_rem;
		logic [QBITS-1:0]  re_q;
		logic [QBITS-1:0]  im_q;
		logic              re_ovf;
		logic              im_ovf;
		logic [DEN_W-1:0]  sq;
		logic [SREM_W-1:0] sq_rem;
		logic [QBITS-1:0]  root;
	} lane_t;

	function automatic logic [MAG_W-1:0] abs_mag(input logic signed [MAG_W-1:0] v);
		abs_mag = v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
	endfunction
endpackage
`default_nettype wire

// ----- hdl/cau_front.sv -----
// Front end: products, sums, operation decode and divider setup.
`default_nettype none
module cau_front #(
	parameter int FRAC_BITS = cau_pkg::DEF_FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic [cau_pkg::ACT_W-1:0]           action,
	input  logic signed [cau_pkg::FIELD_W-1:0]  x_re,
	input  logic signed [cau_pkg::FIELD_W-1:0]  x_im,
	input  logic signed [cau_pkg::FIELD_W-1:0]  y_re,
	input  logic signed [cau_pkg::FIELD_W-1:0]  y_im,
	output logic                                valid_o,
	output cau_pkg::lane_t                      lane_o
);
	localparam int MW = cau_pkg::MAG_W;
	localparam int NW = cau_pkg::MAG_W + FRAC_BITS;

	logic signed [cau_pkg::PROD_W-1:0] p_ac, p_bd, p_ad, p_bc, p_cc, p_dd, p_aa, p_bb;
	logic signed [cau_pkg::PROD_W-1:0] ac_s1, bd_s1, ad_s1, bc_s1, cc_s1, dd_s1, aa_s1, bb_s1;
	logic signed [cau_pkg::FIELD_W:0]  dre, dim, dre_s1, dim_s1;
	logic [cau_pkg::ACT_W-1:0]         act_s1;
	logic                              valid_s1, valid_s2, valid_s3;
	cau_pkg::lane_t                    ln2, ln3, lane_s2, lane_s3;
	logic signed [MW-1:0]              mul_re, mul_im, div_re, div_im;
	logic [cau_pkg::DEN_W-1:0]         den, sq;
	logic [NW-1:0]                     n_re, n_im, r0_re, r0_im;

	assign p_ac = x_re * y_re;
	assign p_bd = x_im * y_im;
	assign p_ad = x_re * y_im;
	assign p_bc = x_im * y_re;
	assign p_cc = y_re * y_re;
	assign p_dd = y_im * y_im;
	assign p_aa = x_re * x_re;
	assign p_bb = x_im * x_im;

	always_comb begin
		case (action)
			cau_pkg::ACT_ADD: begin
				dre = 33'(x_re) + 33'(y_re);
				dim = 33'(x_im) + 33'(y_im);
			end
			cau_pkg::ACT_SUB: begin
				dre = 33'(x_re) - 33'(y_re);
				dim = 33'(x_im) - 33'(y_im);
			end
			cau_pkg::ACT_NEG: begin
				dre = -33'(x_re);
				dim = -33'(x_im);
			end
			default: begin
				dre = '0;
				dim = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		act_s1 <= action;
		dre_s1 <= dre;
		dim_s1 <= dim;
		ac_s1  <= p_ac;
		bd_s1  <= p_bd;
		ad_s1  <= p_ad;
		bc_s1  <= p_bc;
		cc_s1  <= p_cc;
		dd_s1  <= p_dd;
		aa_s1  <= p_aa;
		bb_s1  <= p_bb;
	end

	assign mul_re = MW'(ac_s1) - MW'(bd_s1);
	assign mul_im = MW'(ad_s1) + MW'(bc_s1);
	assign div_re = MW'(ac_s1) + MW'(bd_s1);
	assign div_im = MW'(bc_s1) - MW'(ad_s1);
	assign den    = cau_pkg::DEN_W'(cc_s1) + cau_pkg::DEN_W'(dd_s1);
	assign sq     = cau_pkg::DEN_W'(aa_s1) + cau_pkg::DEN_W'(bb_s1);

	always_comb begin
		ln2        = '0;
		ln2.den    = den;
		ln2.sq     = sq;
		ln2.dz     = (den == '0);
		ln2.kind   = cau_pkg::KIND_DIRECT;
		ln2.re_neg = dre_s1[cau_pkg::FIELD_W];
		ln2.im_neg = dim_s1[cau_pkg::FIELD_W];
		ln2.re_mag = cau_pkg::abs_mag(MW'(dre_s1));
		ln2.im_mag = cau_pkg::abs_mag(MW'(dim_s1));
		case (act_s1)
			cau_pkg::ACT_MUL: begin
				ln2.re_neg = mul_re[MW-1];
				ln2.im_neg = mul_im[MW-1];
				ln2.re_mag = cau_pkg::abs_mag(mul_re) >> FRAC_BITS;
				ln2.im_mag = cau_pkg::abs_mag(mul_im) >> FRAC_BITS;
			end
			cau_pkg::ACT_DIV: begin
				ln2.kind   = cau_pkg::KIND_DIV;
				ln2.re_neg = div_re[MW-1];
				ln2.im_neg = div_im[MW-1];
				ln2.re_mag = cau_pkg::abs_mag(div_re);
				ln2.im_mag = cau_pkg::abs_mag(div_im);
			end
			cau_pkg::ACT_MAG: begin
				ln2.kind   = cau_pkg::KIND_SQRT;
				ln2.re_neg = 1'b0;
				ln2.im_neg = 1'b0;
				ln2.re_mag = '0;
				ln2.im_mag = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		lane_s2 <= ln2;
	end

	assign n_re  = NW'(lane_s2.re_mag) << FRAC_BITS;
	assign n_im  = NW'(lane_s2.im_mag) << FRAC_BITS;
	assign r0_re = n_re >> cau_pkg::QBITS;
	assign r0_im = n_im >> cau_pkg::QBITS;

	always_comb begin
		ln3        = lane_s2;
		ln3.re_rem = r0_re[cau_pkg::DEN_W-1:0];
		ln3.im_rem = r0_im[cau_pkg::DEN_W-1:0];
		ln3.re_ovf = (r0_re >= NW'(lane_s2.den));
		ln3.im_ovf = (r0_im >= NW'(lane_s2.den));
		ln3.re_q   = '0;
		ln3.im_q   = '0;
		ln3.sq_rem = '0;
		ln3.root   = '0;
	end

	always_ff @(posedge clk) begin
		lane_s3 <= ln3;
	end

	assign valid_o = valid_s3;
	assign lane_o  = lane_s3;
endmodule
`default_nettype wire

// ----- hdl/cau_cell.sv -----
// One cell: a quotient bit for both parts and one root bit.
`default_nettype none
module cau_cell #(
	parameter int STEP      = 0,
	parameter int FRAC_BITS = cau_pkg::DEF_FRAC_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_i,
	input  cau_pkg::lane_t lane_i,
	output logic           valid_o,
	output cau_pkg::lane_t lane_o
);
	localparam int DW = cau_pkg::DEN_W;
	localparam int SW = cau_pkg::SREM_W;

	logic          re_nbit, im_nbit;
	logic [1:0]    sbits;
	logic [DW:0]   re_tr, im_tr, den_x;
	logic          re_ge, im_ge, s_ge;
	logic [SW+1:0] s_tr, s_t;
	logic          valid_q;
	cau_pkg::lane_t lane_d, lane_q;

	if (STEP >= FRAC_BITS) begin : g_num
		assign re_nbit = lane_i.re_mag[STEP-FRAC_BITS];
		assign im_nbit = lane_i.im_mag[STEP-FRAC_BITS];
	end else begin : g_frac
		assign re_nbit = 1'b0;
		assign im_nbit = 1'b0;
	end

	if (2*STEP+1 < DW) begin : g_sq
		assign sbits = lane_i.sq[2*STEP+1 -: 2];
	end else begin : g_pad
		assign sbits = 2'b00;
	end

	assign den_x = {1'b0, lane_i.den};
	assign re_tr = {lane_i.re_rem, re_nbit};
	assign im_tr = {lane_i.im_rem, im_nbit};
	assign re_ge = (re_tr >= den_x);
	assign im_ge = (im_tr >= den_x);

	assign s_tr = {lane_i.sq_rem, sbits};
	assign s_t  = (SW+2)'({lane_i.root, 2'b01});
	assign s_ge = (s_tr >= s_t);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_i;
		end
	end

	always_comb begin
		lane_d        = lane_i;
		lane_d.re_rem = re_ge ? DW'(re_tr - den_x) : re_tr[DW-1:0];
		lane_d.im_rem = im_ge ? DW'(im_tr - den_x) : im_tr[DW-1:0];
		lane_d.re_q   = {lane_i.re_q[cau_pkg::QBITS-2:0], re_ge};
		lane_d.im_q   = {lane_i.im_q[cau_pkg::QBITS-2:0], im_ge};
		lane_d.sq_rem = s_ge ? SW'(s_tr - s_t) : s_tr[SW-1:0];
		lane_d.root   = {lane_i.root[cau_pkg::QBITS-2:0], s_ge};
	end

	always_ff @(posedge clk) begin
		lane_q <= lane_d;
	end

	assign valid_o = valid_q;
	assign lane_o  = lane_q;
endmodule
`default_nettype wire

// ----- hdl/cau_pack.sv -----
// Output stage: result selection, saturation and status.
`default_nettype none
module cau_pack #(
	parameter int DATA_WIDTH = cau_pkg::DEF_DATA_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                valid_i,
	input  cau_pkg::lane_t                      lane_i,
	output logic                                done,
	output logic signed [cau_pkg::FIELD_W-1:0]  res_re,
	output logic signed [cau_pkg::FIELD_W-1:0]  res_im,
	output logic [cau_pkg::STAT_W-1:0]          status
);
	localparam int MW   = cau_pkg::MAG_W;
	localparam int WEFF = (DATA_WIDTH > cau_pkg::FIELD_W) ? cau_pkg::FIELD_W : DATA_WIDTH;
	localparam logic [MW-1:0] HALF = MW'(1) << (WEFF - 1);

	logic [MW-1:0] m_re, m_im, lim_re, lim_im, c_re, c_im;
	logic          n_re, n_im, sat_re, sat_im, dz;
	logic [cau_pkg::FIELD_W-1:0] v_re, v_im;
	logic [cau_pkg::STAT_W-1:0]  st;
	logic          done_q;

	always_comb begin
		n_re = lane_i.re_neg;
		n_im = lane_i.im_neg;
		dz   = 1'b0;
		case (lane_i.kind)
			cau_pkg::KIND_DIV: begin
				dz   = lane_i.dz;
				m_re = lane_i.re_ovf ? '1 : MW'(lane_i.re_q);
				m_im = lane_i.im_ovf ? '1 : MW'(lane_i.im_q);
				if (lane_i.dz) begin
					m_re = '0;
					m_im = '0;
				end
			end
			cau_pkg::KIND_SQRT: begin
				n_re = 1'b0;
				n_im = 1'b0;
				m_re = MW'(lane_i.root);
				m_im = '0;
			end
			default: begin
				m_re = lane_i.re_mag;
				m_im = lane_i.im_mag;
			end
		endcase
		lim_re = n_re ? HALF : HALF - MW'(1);
		lim_im = n_im ? HALF : HALF - MW'(1);
		sat_re = (m_re > lim_re);
		sat_im = (m_im > lim_im);
		c_re   = sat_re ? lim_re : m_re;
		c_im   = sat_im ? lim_im : m_im;
		v_re   = n_re ? -c_re[cau_pkg::FIELD_W-1:0] : c_re[cau_pkg::FIELD_W-1:0];
		v_im   = n_im ? -c_im[cau_pkg::FIELD_W-1:0] : c_im[cau_pkg::FIELD_W-1:0];
		if (dz)
			st = cau_pkg::ST_DIV0;
		else if (sat_re || sat_im)
			st = cau_pkg::ST_SAT;
		else
			st = cau_pkg::ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		res_re <= v_re;
		res_im <= v_im;
		status <= st;
	end

	assign done = done_q;
endmodule
`default_nettype wire

// ----- hdl/complex_arithmetic_unit.sv -----
// Top level of the pipelined complex arithmetic unit.
//
//  channel   signals                                 handshake
//  request   start, action, x_re, x_im, y_re, y_im  start && !busy
//  result    done, res_re, res_im, status            done, one cycle
//
// One request per cycle; busy is always low. Every request passes through
// 3 front stages, 34 divider/root cells and 1 output stage, in that order.
// The divider and the square root share the 34-cell chain, one quotient
// bit per part and one root bit per cell. Reset clears the valid bits
// only. Results cannot be stalled.
`default_nettype none
module complex_arithmetic_unit #(
	parameter int DATA_WIDTH = cau_pkg::DEF_DATA_WIDTH,
	parameter int FRAC_BITS  = cau_pkg::DEF_FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [cau_pkg::ACT_W-1:0]           action,
	input  logic signed [cau_pkg::FIELD_W-1:0]  x_re,
	input  logic signed [cau_pkg::FIELD_W-1:0]  x_im,
	input  logic signed [cau_pkg::FIELD_W-1:0]  y_re,
	input  logic signed [cau_pkg::FIELD_W-1:0]  y_im,
	output logic                                done,
	output logic signed [cau_pkg::FIELD_W-1:0]  res_re,
	output logic signed [cau_pkg::FIELD_W-1:0]  res_im,
	output logic [cau_pkg::STAT_W-1:0]          status
);
	localparam int NC = cau_pkg::QBITS;

	logic           valid_c [0:NC];
	cau_pkg::lane_t lane_c  [0:NC];

	assign busy = 1'b0;

	cau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(start && !busy), .action(action),
		.x_re(x_re), .x_im(x_im), .y_re(y_re), .y_im(y_im),
		.valid_o(valid_c[0]), .lane_o(lane_c[0])
	);

	for (genvar j = 0; j < NC; j++) begin : g_cell
		cau_cell #(.STEP(NC - 1 - j), .FRAC_BITS(FRAC_BITS)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.valid_i(valid_c[j]), .lane_i(lane_c[j]),
			.valid_o(valid_c[j+1]), .lane_o(lane_c[j+1])
		);
	end

	cau_pack #(.DATA_WIDTH(DATA_WIDTH)) u_pack (
		.clk(clk), .arst_n(arst_n), .valid_i(valid_c[NC]), .lane_i(lane_c[NC]),
		.done(done), .res_re(res_re), .res_im(res_im), .status(status)
	);
endmodule
`default_nettype wire

// ----- hdl/cau_checker.sv -----
// Port-level checks of the complex arithmetic unit, bound to the top level.
`default_nettype none
module cau_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic                               done,
	input logic [cau_pkg::FIELD_W-1:0]        res_re,
	input logic [cau_pkg::FIELD_W-1:0]        res_im,
	input logic [cau_pkg::STAT_W-1:0]         status
);
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_done_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, cau_pkg::LATENCY))
		else $error("result without request");

	a_done_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(cau_pkg::LATENCY) done)
		else $error("request lost");

	a_div0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == cau_pkg::ST_DIV0) |-> (res_re == '0 && res_im == '0))
		else $error("divide by zero gave nonzero result");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == cau_pkg::ST_OK || status == cau_pkg::ST_SAT ||
			status == cau_pkg::ST_DIV0))
		else $error("bad status");
endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.res_re(res_re), .res_im(res_im), .status(status)
);
`default_nettype wire
